@@ hdl/pidf_pkg.sv @@
package pidf_pkg;

  localparam int unsigned CodeW  = 32;
  localparam int unsigned TickW  = 8;
  localparam int unsigned CountW = 6;
  localparam int unsigned IndexW = 3;

  localparam logic [CountW-1:0] FrameBits = 6'd32;

  localparam logic [TickW-1:0] PreMinRst  = 8'd190;
  localparam logic [TickW-1:0] PreMaxRst  = 8'd232;
  localparam logic [TickW-1:0] ZeroMinRst = 8'd14;
  localparam logic [TickW-1:0] ZeroMaxRst = 8'd20;
  localparam logic [TickW-1:0] OneMinRst  = 8'd30;
  localparam logic [TickW-1:0] OneMaxRst  = 8'd42;

  typedef enum logic [1:0] {
    StIdle = 2'd0,
    StRecv = 2'd1,
    StDone = 2'd2
  } state_e;

  typedef enum logic [2:0] {
    StatIgnored  = 3'd0,
    StatPreamble = 3'd1,
    StatBit      = 3'd2,
    StatValid    = 3'd3,
    StatFailed   = 3'd4,
    StatBad      = 3'd5,
    StatAck      = 3'd6
  } status_e;

  typedef enum logic [IndexW-1:0] {
    RegPreMin  = 3'd0,
    RegPreMax  = 3'd1,
    RegZeroMin = 3'd2,
    RegZeroMax = 3'd3,
    RegOneMin  = 3'd4,
    RegOneMax  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [TickW-1:0] pre_min;
    logic [TickW-1:0] pre_max;
    logic [TickW-1:0] zero_lo;
    logic [TickW-1:0] zero_hi;
    logic [TickW-1:0] one_min;
    logic [TickW-1:0] one_max;
  } windows_t;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             frame_ready;
    status_e          status;
    logic [TickW-1:0] prior_low_byte;
  } result_t;

endpackage

@@ hdl/pidf_step.sv @@
module pidf_step (
  input  pidf_pkg::state_e                state_i,
  input  logic [pidf_pkg::CodeW-1:0]      code_i,
  input  logic [pidf_pkg::CountW-1:0]     count_i,
  input  pidf_pkg::windows_t              win_i,
  input  logic                            command_i,
  input  logic [pidf_pkg::TickW-1:0]      ticks_i,
  output pidf_pkg::state_e                state_o,
  output logic [pidf_pkg::CodeW-1:0]      code_o,
  output logic [pidf_pkg::CountW-1:0]     count_o,
  output pidf_pkg::status_e               status_o
);

  logic                        is_pre;
  logic                        is_one;
  logic                        is_zero;
  logic                        last_bit;
  logic                        bytes_ok;
  logic [pidf_pkg::CodeW-1:0]  shifted;
  logic [pidf_pkg::CountW-1:0] cnt_inc;

  assign is_pre   = (ticks_i >= win_i.pre_min) && (ticks_i <= win_i.pre_max);
  assign is_one   = (ticks_i >= win_i.one_min) && (ticks_i <= win_i.one_max);
  assign is_zero  = (ticks_i >= win_i.zero_lo) && (ticks_i <= win_i.zero_hi);
  assign shifted  = {code_i[pidf_pkg::CodeW-2:0], is_one};
  assign cnt_inc  = count_i + 6'd1;
  assign last_bit = (cnt_inc == pidf_pkg::FrameBits);
  assign bytes_ok = (shifted[31:24] == ~shifted[23:16]) && (shifted[15:8] == ~shifted[7:0]);

  always_comb begin
    state_o = state_i;
    if (command_i) begin
      if (state_i == pidf_pkg::StDone) begin
        state_o = pidf_pkg::StIdle;
      end
    end else begin
      unique case (state_i)
        pidf_pkg::StIdle: begin
          if (is_pre) begin
            state_o = pidf_pkg::StRecv;
          end
        end
        pidf_pkg::StRecv: begin
          if (is_one || is_zero) begin
            if (last_bit) begin
              state_o = bytes_ok ? pidf_pkg::StDone : pidf_pkg::StIdle;
            end
          end else begin
            state_o = pidf_pkg::StIdle;
          end
        end
        pidf_pkg::StDone: state_o = pidf_pkg::StDone;
        default:          state_o = pidf_pkg::StIdle;
      endcase
    end
  end

  always_comb begin
    code_o   = code_i;
    count_o  = count_i;
    status_o = pidf_pkg::StatIgnored;
    if (command_i) begin
      if (state_i == pidf_pkg::StDone) begin
        status_o = pidf_pkg::StatAck;
      end
    end else begin
      unique case (state_i)
        pidf_pkg::StIdle: begin
          if (is_pre) begin
            code_o   = '0;
            count_o  = '0;
            status_o = pidf_pkg::StatPreamble;
          end
        end
        pidf_pkg::StRecv: begin
          code_o = shifted;
          if (is_one || is_zero) begin
            count_o = cnt_inc;
            if (last_bit) begin
              status_o = bytes_ok ? pidf_pkg::StatValid : pidf_pkg::StatFailed;
            end else begin
              status_o = pidf_pkg::StatBit;
            end
          end else begin
            status_o = pidf_pkg::StatBad;
          end
        end
        default: status_o = pidf_pkg::StatIgnored;
      endcase
    end
  end

endmodule

@@ hdl/pulse_distance_ir_frame_decoder_core.sv @@
// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    command_i, interval_ticks_i
// out      out_valid_o / out_ready_i  code_o, frame_ready_o, status_o, prior_low_byte_o
// cfg      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item per cycle while the buffer has a free entry: the decode step is a single pass from the
// state registers into a two-entry result buffer, and each result is registered into that buffer.
// Input is taken while the buffer has a free entry, so one waiting result does not stall it.
// Reset returns the decoder to idle, empties the buffer and loads the default windows.
// Configuration writes are always taken.
module pulse_distance_ir_frame_decoder_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              command_i,
  input  logic [pidf_pkg::TickW-1:0]        interval_ticks_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [pidf_pkg::CodeW-1:0]        code_o,
  output logic                              frame_ready_o,
  output logic [2:0]                        status_o,
  output logic [pidf_pkg::TickW-1:0]        prior_low_byte_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pidf_pkg::IndexW-1:0]       cfg_index_i,
  input  logic [pidf_pkg::TickW-1:0]        cfg_data_i
);

  pidf_pkg::state_e            state_q, state_d;
  logic [pidf_pkg::CodeW-1:0]  code_q, code_d;
  logic [pidf_pkg::CountW-1:0] count_q, count_d;
  pidf_pkg::windows_t          win_q, win_d;
  pidf_pkg::status_e           status_d;
  pidf_pkg::result_t           res_d;
  pidf_pkg::result_t           head_q, head_d;
  pidf_pkg::result_t           skid_q, skid_d;
  logic [1:0]                  fill_q, fill_d;
  logic                        push;
  logic                        pop;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (fill_q != 2'd2);
  assign out_valid_o = (fill_q != 2'd0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  pidf_step u_step (
    .state_i   (state_q),
    .code_i    (code_q),
    .count_i   (count_q),
    .win_i     (win_q),
    .command_i (command_i),
    .ticks_i   (interval_ticks_i),
    .state_o   (state_d),
    .code_o    (code_d),
    .count_o   (count_d),
    .status_o  (status_d)
  );

  assign res_d.code           = code_d;
  assign res_d.frame_ready    = (state_d == pidf_pkg::StDone);
  assign res_d.status         = status_d;
  assign res_d.prior_low_byte = code_q[pidf_pkg::TickW-1:0];

  always_comb begin
    win_d = win_q;
    if (cfg_valid_i) begin
      unique case (pidf_pkg::reg_idx_e'(cfg_index_i))
        pidf_pkg::RegPreMin:  win_d.pre_min  = cfg_data_i;
        pidf_pkg::RegPreMax:  win_d.pre_max  = cfg_data_i;
        pidf_pkg::RegZeroMin: win_d.zero_lo  = cfg_data_i;
        pidf_pkg::RegZeroMax: win_d.zero_hi  = cfg_data_i;
        pidf_pkg::RegOneMin:  win_d.one_min  = cfg_data_i;
        pidf_pkg::RegOneMax:  win_d.one_max  = cfg_data_i;
        default:              win_d          = win_q;
      endcase
    end
  end

  always_comb begin
    head_d = head_q;
    skid_d = skid_q;
    fill_d = fill_q;
    if (push && pop) begin
      if (fill_q == 2'd1) begin
        head_d = res_d;
      end else begin
        head_d = skid_q;
        skid_d = res_d;
      end
    end else if (pop) begin
      head_d = skid_q;
      fill_d = fill_q - 2'd1;
    end else if (push) begin
      if (fill_q == 2'd0) begin
        head_d = res_d;
      end else begin
        skid_d = res_d;
      end
      fill_d = fill_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pidf_pkg::StIdle;
      fill_q       <= 2'd0;
      win_q.pre_min  <= pidf_pkg::PreMinRst;
      win_q.pre_max  <= pidf_pkg::PreMaxRst;
      win_q.zero_lo  <= pidf_pkg::ZeroMinRst;
      win_q.zero_hi  <= pidf_pkg::ZeroMaxRst;
      win_q.one_min  <= pidf_pkg::OneMinRst;
      win_q.one_max  <= pidf_pkg::OneMaxRst;
    end else begin
      fill_q <= fill_d;
      win_q  <= win_d;
      if (push) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
    if (push) begin
      code_q  <= code_d;
      count_q <= count_d;
    end
  end

  assign code_o           = head_q.code;
  assign frame_ready_o    = head_q.frame_ready;
  assign status_o         = head_q.status;
  assign prior_low_byte_o = head_q.prior_low_byte;

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> out_valid_o)
    else $error("accepted item left no result");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && (fill_q == 2'd2)))
    else $error("input stalled without a full buffer");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == pidf_pkg::StatValid)) |-> frame_ready_o)
    else $error("valid frame not held");

  a_ack_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == pidf_pkg::StatAck)) |-> !frame_ready_o)
    else $error("acknowledge left frame held");

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 500000;
  localparam logic [pidf_pkg::IndexW-1:0] RegSpareLo = 3'd6;
  localparam logic [pidf_pkg::IndexW-1:0] RegSpareHi = 3'd7;

  typedef struct packed {
    logic                       cmd;
    logic [pidf_pkg::TickW-1:0] ticks;
  } ir_event_t;

  typedef struct {
    pidf_pkg::result_t res;
    bit                prior_known;
  } decode_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready_o;
  logic                          command = 1'b0;
  logic [pidf_pkg::TickW-1:0]    interval = '0;
  logic                          out_valid_o;
  logic                          out_ready = 1'b0;
  logic [pidf_pkg::CodeW-1:0]    code_o;
  logic                          frame_ready_o;
  logic [2:0]                    status_o;
  logic [pidf_pkg::TickW-1:0]    prior_low_byte_o;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready_o;
  logic [pidf_pkg::IndexW-1:0]   cfg_index = '0;
  logic [pidf_pkg::TickW-1:0]    cfg_data = '0;

  pulse_distance_ir_frame_decoder_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .command_i        (command),
    .interval_ticks_i (interval),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .code_o           (code_o),
    .frame_ready_o    (frame_ready_o),
    .status_o         (status_o),
    .prior_low_byte_o (prior_low_byte_o),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  // Decoder state as the block should hold it.
  pidf_pkg::windows_t          win;
  pidf_pkg::state_e            dec_state;
  logic [pidf_pkg::CodeW-1:0]  sh_code;
  logic [pidf_pkg::CountW-1:0] bit_cnt;
  bit                          code_written;

  ir_event_t ir_events[$];
  decode_t   expected_decodes[$];
  int unsigned events_queued;
  int unsigned events_accepted;
  int unsigned failures;
  int unsigned cycles;

  ir_event_t next_event;
  decode_t   want;
  int        burst_left;
  int        gap_left;
  int        stall_mode;
  int        stall_left;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit in_window(logic [pidf_pkg::TickW-1:0] t,
                                   logic [pidf_pkg::TickW-1:0] lo,
                                   logic [pidf_pkg::TickW-1:0] hi);
    return t >= lo && t <= hi;
  endfunction

  function automatic decode_t decode_step(logic cmd, logic [pidf_pkg::TickW-1:0] t);
    decode_t r;
    pidf_pkg::status_e st;
    r.prior_known = code_written;
    r.res.prior_low_byte = sh_code[7:0];
    st = pidf_pkg::StatIgnored;
    if (cmd) begin
      if (dec_state == pidf_pkg::StDone) begin
        dec_state = pidf_pkg::StIdle;
        st = pidf_pkg::StatAck;
      end
    end else begin
      case (dec_state)
        pidf_pkg::StIdle: begin
          if (in_window(t, win.pre_min, win.pre_max)) begin
            sh_code = '0;
            bit_cnt = '0;
            code_written = 1'b1;
            dec_state = pidf_pkg::StRecv;
            st = pidf_pkg::StatPreamble;
          end
        end
        pidf_pkg::StRecv: begin
          sh_code = sh_code << 1;
          if (in_window(t, win.one_min, win.one_max)) begin
            sh_code[0] = 1'b1;
            bit_cnt = bit_cnt + 6'd1;
            st = pidf_pkg::StatBit;
          end else if (in_window(t, win.zero_lo, win.zero_hi)) begin
            bit_cnt = bit_cnt + 6'd1;
            st = pidf_pkg::StatBit;
          end else begin
            dec_state = pidf_pkg::StIdle;
            st = pidf_pkg::StatBad;
          end
          if (st == pidf_pkg::StatBit && bit_cnt == pidf_pkg::FrameBits) begin
            if (sh_code[31:24] == ~sh_code[23:16] && sh_code[15:8] == ~sh_code[7:0]) begin
              dec_state = pidf_pkg::StDone;
              st = pidf_pkg::StatValid;
            end else begin
              dec_state = pidf_pkg::StIdle;
              st = pidf_pkg::StatFailed;
            end
          end
        end
        pidf_pkg::StDone: ;
        default: dec_state = pidf_pkg::StIdle;
      endcase
    end
    r.res.code = sh_code;
    r.res.frame_ready = (dec_state == pidf_pkg::StDone);
    r.res.status = st;
    return r;
  endfunction

  function automatic void set_window(logic [pidf_pkg::IndexW-1:0] idx,
                                     logic [pidf_pkg::TickW-1:0] val);
    case (idx)
      pidf_pkg::RegPreMin:  win.pre_min = val;
      pidf_pkg::RegPreMax:  win.pre_max = val;
      pidf_pkg::RegZeroMin: win.zero_lo = val;
      pidf_pkg::RegZeroMax: win.zero_hi = val;
      pidf_pkg::RegOneMin:  win.one_min = val;
      pidf_pkg::RegOneMax:  win.one_max = val;
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      command <= 1'b0;
      interval <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready_o) begin
        expected_decodes.push_back(decode_step(command, interval));
        events_accepted++;
      end
      if (!in_valid || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (ir_events.size() != 0) begin
          next_event = ir_events.pop_front();
          in_valid <= 1'b1;
          command <= next_event.cmd;
          interval <= next_event.ticks;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_mode = 0;
      stall_left = 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 80);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= stall_left[0];
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_decodes.size() == 0) begin
        $error("result with nothing expected: code %h status %0d", code_o, status_o);
        failures++;
      end else begin
        want = expected_decodes.pop_front();
        if (code_o !== want.res.code) begin
          $error("code: expected %h, got %h", want.res.code, code_o);
          failures++;
        end
        if (frame_ready_o !== want.res.frame_ready) begin
          $error("frame_ready: expected %0d, got %0d", want.res.frame_ready, frame_ready_o);
          failures++;
        end
        if (status_o !== want.res.status) begin
          $error("status: expected %0d, got %0d", want.res.status, status_o);
          failures++;
        end
        if (want.prior_known && prior_low_byte_o !== want.res.prior_low_byte) begin
          $error("prior_low_byte: expected %h, got %h", want.res.prior_low_byte,
                 prior_low_byte_o);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic push_event(logic cmd, logic [pidf_pkg::TickW-1:0] ticks);
    ir_events.push_back('{cmd: cmd, ticks: ticks});
    events_queued++;
  endtask

  function automatic logic [pidf_pkg::TickW-1:0] pick_zero();
    logic [pidf_pkg::TickW-1:0] t;
    for (int k = 0; k < 20; k++) begin
      t = 8'($urandom_range(win.zero_hi, win.zero_lo));
      if (!in_window(t, win.one_min, win.one_max)) return t;
    end
    return t;
  endfunction

  function automatic bit pick_bad(output logic [pidf_pkg::TickW-1:0] t);
    for (int k = 0; k < 64; k++) begin
      t = 8'($urandom);
      if (!in_window(t, win.one_min, win.one_max) && !in_window(t, win.zero_lo, win.zero_hi))
        return 1'b1;
    end
    return 1'b0;
  endfunction

  // A well-formed frame with random content, or one that fails its check or is cut short.
  task automatic push_frame();
    logic [pidf_pkg::CodeW-1:0] word;
    logic [pidf_pkg::TickW-1:0] bad;
    int kind;
    int cut;
    bit have_bad;
    kind = $urandom_range(0, 9);
    word = $urandom;
    word[31:24] = ~word[23:16];
    word[15:8] = ~word[7:0];
    have_bad = pick_bad(bad);
    if (kind >= 8 && !have_bad) kind = 6;
    if (kind == 6 || kind == 7) begin
      cut = $urandom_range(31, 0);
      word[cut] = ~word[cut];
    end
    cut = $urandom_range(31, 0);
    push_event(1'b0, 8'($urandom_range(win.pre_max, win.pre_min)));
    for (int i = 31; i >= 0; i--) begin
      if (kind >= 8 && i == cut) begin
        push_event(1'b0, bad);
        break;
      end
      if ($urandom_range(0, 19) == 0) push_event(1'b1, 8'($urandom));
      push_event(1'b0, word[i] ? 8'($urandom_range(win.one_max, win.one_min)) : pick_zero());
    end
    if (kind < 6) begin
      repeat ($urandom_range(0, 2)) push_event(1'b0, 8'($urandom));
      if ($urandom_range(0, 7) != 0) push_event(1'b1, 8'($urandom));
    end
  endtask

  task automatic drain();
    while (events_accepted != events_queued || expected_decodes.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_traffic(int unsigned n);
    int unsigned start;
    bit framing;
    start = events_queued;
    framing = win.pre_min <= win.pre_max && win.one_min <= win.one_max &&
              win.zero_lo <= win.zero_hi;
    while (events_queued - start < n) begin
      if (framing && $urandom_range(0, 9) < 8) begin
        push_frame();
      end else begin
        repeat ($urandom_range(1, 4)) push_event($urandom_range(0, 3) == 0, 8'($urandom));
      end
    end
    drain();
  endtask

  task automatic write_reg(logic [pidf_pkg::IndexW-1:0] idx, logic [pidf_pkg::TickW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    set_window(idx, val);
  endtask

  task automatic load_windows(pidf_pkg::windows_t w);
    write_reg(pidf_pkg::RegPreMin, w.pre_min);
    write_reg(pidf_pkg::RegPreMax, w.pre_max);
    write_reg(pidf_pkg::RegZeroMin, w.zero_lo);
    write_reg(pidf_pkg::RegZeroMax, w.zero_hi);
    write_reg(pidf_pkg::RegOneMin, w.one_min);
    write_reg(pidf_pkg::RegOneMax, w.one_max);
  endtask

  initial begin
    win = '{pre_min: pidf_pkg::PreMinRst, pre_max: pidf_pkg::PreMaxRst,
            zero_lo: pidf_pkg::ZeroMinRst, zero_hi: pidf_pkg::ZeroMaxRst,
            one_min: pidf_pkg::OneMinRst, one_max: pidf_pkg::OneMaxRst};
    dec_state = pidf_pkg::StIdle;
    sh_code = '0;
    bit_cnt = '0;
    code_written = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The shift register holds nothing until a preamble, so the run opens with one.
    push_event(1'b0, 8'd190);
    push_event(1'b0, 8'd14);
    push_event(1'b0, 8'd20);
    push_event(1'b0, 8'd30);
    push_event(1'b0, 8'd42);
    push_event(1'b0, 8'd21);
    push_event(1'b0, 8'd0);
    push_event(1'b1, 8'd255);
    push_event(1'b0, 8'd255);
    push_event(1'b0, 8'd189);
    push_event(1'b0, 8'd233);
    push_event(1'b0, 8'd232);
    push_event(1'b0, 8'd31);
    push_event(1'b0, 8'd29);
    push_event(1'b0, 8'd200);
    push_event(1'b0, 8'd13);
    push_event(1'b0, 8'd200);
    push_event(1'b0, 8'd43);
    push_event(1'b1, 8'd0);
    run_traffic(500);

    load_windows('{pre_min: 8'd255, pre_max: 8'd255, zero_lo: 8'd0, zero_hi: 8'd0,
                   one_min: 8'd1, one_max: 8'd1});
    write_reg(RegSpareLo, 8'($urandom));
    cfg_valid <= 1'b0;
    run_traffic(300);

    // Overlapping bit windows: an interval in both decodes as a one.
    load_windows('{pre_min: 8'd0, pre_max: 8'd20, zero_lo: 8'd30, zero_hi: 8'd90,
                   one_min: 8'd60, one_max: 8'd120});
    cfg_valid <= 1'b0;
    run_traffic(350);

    load_windows('{pre_min: 8'd0, pre_max: 8'd255, zero_lo: 8'd0, zero_hi: 8'd255,
                   one_min: 8'd128, one_max: 8'd255});
    cfg_valid <= 1'b0;
    run_traffic(300);

    load_windows('{pre_min: 8'd200, pre_max: 8'd100, zero_lo: 8'($urandom),
                   zero_hi: 8'($urandom), one_min: 8'($urandom), one_max: 8'($urandom)});
    write_reg(RegSpareHi, 8'($urandom));
    cfg_valid <= 1'b0;
    run_traffic(24);

    load_windows('{pre_min: pidf_pkg::PreMinRst, pre_max: pidf_pkg::PreMaxRst,
                   zero_lo: pidf_pkg::ZeroMinRst, zero_hi: pidf_pkg::ZeroMaxRst,
                   one_min: pidf_pkg::OneMinRst, one_max: pidf_pkg::OneMaxRst});
    cfg_valid <= 1'b0;
    run_traffic(350);

    repeat (8) @(posedge clk_i);
    if (failures == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/pidf_pkg.sv
hdl/pidf_step.sv
hdl/pulse_distance_ir_frame_decoder_core.sv
tb/tb_top.sv
